/* src/fst_pkg.sv */
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants for the fetch slot table.
// ----------------------------------------------------------------------------
package fst_pkg;

    localparam logic [1:0] ACT_FETCH    = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;
    localparam logic [1:0] ACT_DROP     = 2'd3;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;
    localparam logic [1:0] ST_FAILED  = 2'd3;

    localparam logic REG_ENABLED     = 1'b0;
    localparam logic REG_MAX_PENDING = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic        remote;
        logic [4:0]  slot;
        logic        got;
        logic [31:0] body_ref;
        logic [30:0] body_len;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  fetch_state;
        logic [4:0]  slot_index;
        logic [31:0] result_ref;
        logic [30:0] result_len;
        logic [4:0]  pending_count;
        logic        notify;
    } out_item_t;

endpackage

/* src/fst_front.sv */
// ----------------------------------------------------------------------------
// fst_front
// Accepts items and classifies them into a one-entry queue for the back end.
// ----------------------------------------------------------------------------
module fst_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fst_pkg::in_item_t in_item,
    output logic             busy,
    output logic             q_valid,
    output fst_pkg::in_item_t q_item,
    output logic             q_fetch_fail,
    input  logic             q_take
);
    logic              valid_reg;
    fst_pkg::in_item_t item_reg;
    logic              fail_reg;

    assign busy         = valid_reg;
    assign q_valid      = valid_reg;
    assign q_item       = item_reg;
    assign q_fetch_fail = fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (start && !valid_reg)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !valid_reg)
        begin
            item_reg <= in_item;
            // non-remote fetch answers immediately in the back end
            fail_reg <= (in_item.action == fst_pkg::ACT_FETCH) && !in_item.remote;
        end
    end
endmodule

/* src/fst_back.sv */
// ----------------------------------------------------------------------------
// fst_back
// Slot table and scanning sequencer: one slot examined per cycle.
// ----------------------------------------------------------------------------
module fst_back #(
    parameter int SLOTS    = 24,
    parameter int KEY_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enabled,
    input  logic [4:0]        max_pending,
    input  logic              q_valid,
    input  fst_pkg::in_item_t q_item,
    input  logic              q_fetch_fail,
    output logic              q_take,
    output logic              done,
    output fst_pkg::out_item_t result
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_VICTIM = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg;

    logic [1:0]          st_reg   [SLOTS];
    logic                dis_reg  [SLOTS];
    logic [KEY_BITS-1:0] key_mem  [SLOTS];
    logic [31:0]         ref_mem  [SLOTS];
    logic [30:0]         len_mem  [SLOTS];

    logic [IW-1:0] idx_reg;
    logic [IW:0]   cnt_reg;
    logic [IW-1:0] ptr_reg;
    logic [CW-1:0] inflight_reg;
    fst_pkg::out_item_t res_reg;
    logic          done_reg;

    logic [KEY_BITS-1:0] qkey;
    logic [IW-1:0]       idx_inc;
    logic                cslot_ok;
    logic [IW-1:0]       cslot;
    logic                can_start;
    logic                c_hit;
    fst_pkg::out_item_t  quick_res;

    assign qkey     = KEY_BITS'(q_item.key);
    assign idx_inc  = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
    assign cslot_ok = int'(q_item.slot) < SLOTS;
    assign cslot    = IW'(q_item.slot);
    assign can_start = enabled && (7'(inflight_reg) < 7'(max_pending));
    assign c_hit    = cslot_ok && st_reg[cslot] == fst_pkg::ST_PENDING;

    // answer for items that finish without a scan
    always_comb
    begin
        quick_res = '0;
        quick_res.pending_count = 5'(inflight_reg);
        if (q_item.action == fst_pkg::ACT_FETCH)
        begin
            quick_res.fetch_state = fst_pkg::ST_FAILED;
        end
        else if (c_hit)
        begin
            quick_res.notify = !dis_reg[cslot];
            if (inflight_reg != '0)
            begin
                quick_res.pending_count = 5'(inflight_reg - 1'b1);
            end
        end
    end

    assign q_take = (state_reg == S_OUT);
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            ptr_reg      <= '0;
            inflight_reg <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i]  <= fst_pkg::ST_NONE;
                dis_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        idx_reg       <= '0;
                        cnt_reg       <= '0;
                        if (q_item.action == fst_pkg::ACT_FETCH && q_fetch_fail)
                        begin
                            res_reg   <= quick_res;
                            state_reg <= S_OUT;
                            done_reg  <= 1'b1;
                        end
                        else if (q_item.action == fst_pkg::ACT_COMPLETE)
                        begin
                            res_reg <= quick_res;
                            if (c_hit)
                            begin
                                if (dis_reg[cslot])
                                begin
                                    st_reg[cslot] <= fst_pkg::ST_NONE;
                                end
                                else
                                begin
                                    st_reg[cslot] <= q_item.got ? fst_pkg::ST_DONE
                                                                : fst_pkg::ST_FAILED;
                                    ref_mem[cslot] <= q_item.got ? q_item.body_ref : '0;
                                    len_mem[cslot] <= q_item.got ? q_item.body_len : '0;
                                end
                                dis_reg[cslot] <= 1'b0;
                                if (inflight_reg != '0)
                                begin
                                    inflight_reg <= inflight_reg - 1'b1;
                                end
                            end
                            state_reg <= S_OUT;
                            done_reg  <= 1'b1;
                        end
                        else if (q_item.action == fst_pkg::ACT_CLEAR)
                        begin
                            res_reg   <= '0;
                            ptr_reg   <= '0;
                            state_reg <= S_SWEEP;
                        end
                        else
                        begin
                            res_reg   <= '0;
                            state_reg <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP:
                begin
                    // fetch: first live key match; drop: first finished key match
                    if (key_mem[idx_reg] == qkey &&
                        ((q_item.action == fst_pkg::ACT_FETCH &&
                          st_reg[idx_reg] != fst_pkg::ST_NONE) ||
                         (q_item.action == fst_pkg::ACT_DROP &&
                          (st_reg[idx_reg] == fst_pkg::ST_DONE ||
                           st_reg[idx_reg] == fst_pkg::ST_FAILED))))
                    begin
                        res_reg.pending_count <= 5'(inflight_reg);
                        if (q_item.action == fst_pkg::ACT_FETCH)
                        begin
                            res_reg.fetch_state <= st_reg[idx_reg];
                            res_reg.slot_index  <= 5'(idx_reg);
                            if (st_reg[idx_reg] == fst_pkg::ST_DONE)
                            begin
                                res_reg.result_ref <= ref_mem[idx_reg];
                                res_reg.result_len <= len_mem[idx_reg];
                            end
                        end
                        else
                        begin
                            st_reg[idx_reg]  <= fst_pkg::ST_NONE;
                            dis_reg[idx_reg] <= 1'b0;
                        end
                        state_reg <= S_OUT;
                        done_reg  <= 1'b1;
                    end
                    else if (idx_reg == LAST)
                    begin
                        res_reg.pending_count <= 5'(inflight_reg);
                        if (q_item.action == fst_pkg::ACT_FETCH && can_start)
                        begin
                            idx_reg   <= ptr_reg;
                            cnt_reg   <= '0;
                            state_reg <= S_VICTIM;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                            done_reg  <= 1'b1;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_VICTIM:
                begin
                    if (st_reg[idx_reg] != fst_pkg::ST_PENDING)
                    begin
                        st_reg[idx_reg]  <= fst_pkg::ST_PENDING;
                        dis_reg[idx_reg] <= 1'b0;
                        key_mem[idx_reg] <= qkey;
                        ref_mem[idx_reg] <= '0;
                        len_mem[idx_reg] <= '0;
                        ptr_reg <= idx_inc;
                        res_reg.fetch_state <= fst_pkg::ST_PENDING;
                        res_reg.slot_index  <= 5'(idx_reg);
                        if (inflight_reg < CW'(SLOTS))
                        begin
                            inflight_reg <= inflight_reg + 1'b1;
                            res_reg.pending_count <= 5'(inflight_reg + 1'b1);
                        end
                        state_reg <= S_OUT;
                        done_reg  <= 1'b1;
                    end
                    else if (cnt_reg == (IW+1)'(SLOTS - 1))
                    begin
                        state_reg <= S_OUT;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SWEEP:
                begin
                    if (st_reg[idx_reg] != fst_pkg::ST_PENDING)
                    begin
                        st_reg[idx_reg]  <= fst_pkg::ST_NONE;
                        dis_reg[idx_reg] <= 1'b0;
                        key_mem[idx_reg] <= '0;
                    end
                    else
                    begin
                        dis_reg[idx_reg] <= 1'b1;
                    end
                    if (idx_reg == LAST)
                    begin
                        res_reg.pending_count <= 5'(inflight_reg);
                        state_reg <= S_OUT;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* src/fetch_slot_table.sv */
// ----------------------------------------------------------------------------
// fetch_slot_table
// Request slot table keyed by URL tag with round-robin slot replacement.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// item in   | start / busy         | in_item (fst_pkg::in_item_t)
// result    | done strobe          | result (fst_pkg::out_item_t)
// config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Fetch and drop scan the slots one per cycle: a lookup pass over up to SLOTS
// slots, then, on a fetch miss that may claim a slot, a victim pass over them.
// Clear sweeps all slots. Completion and non-remote fetch answer without a scan.
// Reset empties all slots at once. The result receiver cannot stall.
module fetch_slot_table #(
    parameter int SLOTS    = 24,
    parameter int KEY_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fst_pkg::in_item_t  in_item,
    output logic               done,
    output fst_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);
    logic              enabled_reg;
    logic [4:0]        max_pending_reg;
    logic              q_valid;
    fst_pkg::in_item_t q_item;
    logic              q_fail;
    logic              q_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b1;
            max_pending_reg <= 5'd4;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == fst_pkg::REG_ENABLED)
            begin
                enabled_reg <= cfg_data[0];
            end
            else
            begin
                max_pending_reg <= cfg_data;
            end
        end
    end

    fst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_item      (in_item),
        .busy         (busy),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_fetch_fail (q_fail),
        .q_take       (q_take)
    );

    fst_back #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .enabled      (enabled_reg),
        .max_pending  (max_pending_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_fetch_fail (q_fail),
        .q_take       (q_take),
        .done         (done),
        .result       (result)
    );
endmodule

/* src/fst_checker.sv */
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks for the fetch slot table.
// ----------------------------------------------------------------------------
module fst_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input fst_pkg::out_item_t result
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result without an item in progress");
    a_notify: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.notify |-> result.fetch_state == fst_pkg::ST_NONE)
        else $error("notify on a fetch answer");
endmodule

bind fetch_slot_table fst_checker u_fst_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* verif/tb_fetch_slot_table.sv */
// ----------------------------------------------------------------------------
// tb_fetch_slot_table
// Self-checking bench for the fetch slot table: directed and random items
// against an in-bench slot table predictor, with register changes in between.
// ----------------------------------------------------------------------------
module tb_fetch_slot_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 24;
    localparam int STALL_LIMIT = 20000;
    localparam int IN_BITS = $bits(fst_pkg::in_item_t);

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    fst_pkg::in_item_t  in_item;
    logic               done;
    fst_pkg::out_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [4:0]         cfg_data;

    fetch_slot_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic        tbl_enabled;
    logic [4:0]  tbl_max_pending;
    logic [1:0]  tbl_state [NSLOT];
    logic [31:0] tbl_key [NSLOT];
    logic [31:0] tbl_ref [NSLOT];
    logic [30:0] tbl_len [NSLOT];
    logic        tbl_discard [NSLOT];
    logic [4:0]  tbl_in_flight;
    logic [4:0]  tbl_victim;

    fst_pkg::out_item_t answers_due[$];
    int          mismatches = 0;
    int          idle_cycles;
    logic [31:0] recent_keys[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic fst_pkg::in_item_t rand_item();
        return fst_pkg::in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom}));
    endfunction

    function automatic void empty_entry(int i);
        tbl_state[i] = fst_pkg::ST_NONE;
        tbl_key[i] = '0;
        tbl_ref[i] = '0;
        tbl_len[i] = '0;
        tbl_discard[i] = 1'b0;
    endfunction

    function automatic void table_reset();
        tbl_enabled = 1'b1;
        tbl_max_pending = 5'd4;
        for (int i = 0; i < NSLOT; i++)
            empty_entry(i);
        tbl_in_flight = '0;
        tbl_victim = '0;
    endfunction

    function automatic fst_pkg::out_item_t table_step(fst_pkg::in_item_t it);
        fst_pkg::out_item_t r;
        bit hit;
        int ix;
        r = '0;
        hit = 0;
        case (it.action)
            fst_pkg::ACT_FETCH:
            begin
                if (!it.remote)
                    r.fetch_state = fst_pkg::ST_FAILED;
                else
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (!hit && tbl_state[i] != fst_pkg::ST_NONE && tbl_key[i] == it.key)
                        begin
                            hit = 1;
                            r.fetch_state = tbl_state[i];
                            r.slot_index = i[4:0];
                            if (tbl_state[i] == fst_pkg::ST_DONE)
                            begin
                                r.result_ref = tbl_ref[i];
                                r.result_len = tbl_len[i];
                            end
                        end
                    if (!hit && tbl_enabled && tbl_in_flight < tbl_max_pending)
                    begin
                        for (int i = 0; i < NSLOT; i++)
                        begin
                            ix = (int'(tbl_victim) + i) % NSLOT;
                            if (!hit && tbl_state[ix] != fst_pkg::ST_PENDING)
                            begin
                                hit = 1;
                                tbl_victim = 5'((ix + 1) % NSLOT);
                                empty_entry(ix);
                                tbl_key[ix] = it.key;
                                tbl_state[ix] = fst_pkg::ST_PENDING;
                                if (tbl_in_flight < NSLOT)
                                    tbl_in_flight++;
                                r.fetch_state = fst_pkg::ST_PENDING;
                                r.slot_index = 5'(ix);
                            end
                        end
                    end
                end
            end
            fst_pkg::ACT_COMPLETE:
            begin
                if (it.slot < NSLOT && tbl_state[it.slot] == fst_pkg::ST_PENDING)
                begin
                    if (tbl_discard[it.slot])
                        empty_entry(it.slot);
                    else
                    begin
                        if (it.got)
                        begin
                            tbl_ref[it.slot] = it.body_ref;
                            tbl_len[it.slot] = it.body_len;
                            tbl_state[it.slot] = fst_pkg::ST_DONE;
                        end
                        else
                            tbl_state[it.slot] = fst_pkg::ST_FAILED;
                        r.notify = 1'b1;
                    end
                    if (tbl_in_flight > 0)
                        tbl_in_flight--;
                end
            end
            fst_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_state[i] != fst_pkg::ST_PENDING)
                        empty_entry(i);
                    else
                        tbl_discard[i] = 1'b1;
                tbl_victim = '0;
            end
            default:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (!hit && (tbl_state[i] == fst_pkg::ST_DONE ||
                                 tbl_state[i] == fst_pkg::ST_FAILED)
                        && tbl_key[i] == it.key)
                    begin
                        hit = 1;
                        empty_entry(i);
                    end
            end
        endcase
        r.pending_count = tbl_in_flight;
        return r;
    endfunction

    // mostly short gaps, a few long ones, often none
    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50)
            n = 0;
        else if (n < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(fst_pkg::in_item_t it);
        random_gap();
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        answers_due.push_back(table_step(it));
        start <= 1'b0;
        in_item <= rand_item();
        // busy stays high through the next edge anyway
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == fst_pkg::REG_ENABLED)
            tbl_enabled = val[0];
        else
            tbl_max_pending = val;
        @(posedge clk);
    endtask

    function automatic fst_pkg::in_item_t mk_fetch(logic [31:0] k, logic rem);
        fst_pkg::in_item_t it;
        it = rand_item();
        it.action = fst_pkg::ACT_FETCH;
        it.key = k;
        it.remote = rem;
        return it;
    endfunction

    function automatic fst_pkg::in_item_t mk_complete(logic [4:0] s, logic g,
                                                      logic [31:0] br, logic [30:0] bl);
        fst_pkg::in_item_t it;
        it = rand_item();
        it.action = fst_pkg::ACT_COMPLETE;
        it.slot = s;
        it.got = g;
        it.body_ref = br;
        it.body_len = bl;
        return it;
    endfunction

    function automatic fst_pkg::in_item_t mk_other(logic [1:0] act, logic [31:0] k);
        fst_pkg::in_item_t it;
        it = rand_item();
        it.action = act;
        it.key = k;
        return it;
    endfunction

    task automatic test_directed();
        send_item(mk_fetch(32'h0, 1'b0));
        send_item(mk_fetch(32'hFFFF_FFFF, 1'b1));
        send_item(mk_fetch(32'h0, 1'b1));
        send_item(mk_fetch(32'hFFFF_FFFF, 1'b1));
        send_item(mk_complete(5'd0, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        send_item(mk_complete(5'd1, 1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        send_item(mk_fetch(32'hFFFF_FFFF, 1'b1));
        send_item(mk_fetch(32'h0, 1'b1));
        send_item(mk_complete(5'd31, 1'b1, 32'h1, 31'h1));
        send_item(mk_complete(5'd23, 1'b1, 32'h1, 31'h1));
        send_item(mk_complete(5'd0, 1'b1, 32'h1, 31'h1));
        for (int i = 0; i < 5; i++)
            send_item(mk_fetch(32'h100 + i, 1'b1));
        send_item(mk_other(fst_pkg::ACT_CLEAR, 32'h0));
        send_item(mk_complete(5'd2, 1'b1, 32'h55, 31'h66));
        send_item(mk_fetch(32'h100, 1'b1));
        send_item(mk_other(fst_pkg::ACT_DROP, 32'hFFFF_FFFF));
        send_item(mk_other(fst_pkg::ACT_DROP, 32'h0));
        for (int i = 0; i < 5; i++)
            send_item(mk_complete(5'(i), 1'b0, 32'h0, 31'h0));
        wait_drained();
    endtask

    // every slot pending, then the remaining fetches must find nothing claimable
    task automatic test_full_table();
        write_reg(fst_pkg::REG_MAX_PENDING, 5'd31);
        write_reg(fst_pkg::REG_ENABLED, 5'd1);
        for (int i = 0; i < NSLOT + 2; i++)
            send_item(mk_fetch(32'h9000 + i, 1'b1));
        for (int i = 0; i < NSLOT; i++)
            send_item(mk_complete(5'(i), i[0], $urandom, 31'($urandom)));
        send_item(mk_other(fst_pkg::ACT_CLEAR, 32'h0));
        wait_drained();
    endtask

    task automatic test_disabled();
        write_reg(fst_pkg::REG_ENABLED, 5'd0);
        for (int i = 0; i < 4; i++)
            send_item(mk_fetch($urandom, 1'b1));
        wait_drained();
        write_reg(fst_pkg::REG_ENABLED, 5'd1);
        write_reg(fst_pkg::REG_MAX_PENDING, 5'd0);
        send_item(mk_fetch(32'h77, 1'b1));
        wait_drained();
    endtask

    function automatic logic [31:0] pick_key();
        if (recent_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return $urandom;
    endfunction

    task automatic run_random(int count);
        int p;
        logic [31:0] k;
        logic [4:0] s;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 45)
            begin
                k = pick_key();
                if (recent_keys.size() < 12)
                    recent_keys.push_back(k);
                else
                    recent_keys[$urandom_range(0, 11)] = k;
                send_item(mk_fetch(k, $urandom_range(0, 9) != 0));
            end
            else if (p < 85)
            begin
                // mostly aim at a slot that is in flight
                s = 5'($urandom_range(0, 31));
                if ($urandom_range(0, 4) != 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (tbl_state[i] == fst_pkg::ST_PENDING && $urandom_range(0, 2) == 0)
                            s = 5'(i);
                send_item(mk_complete(s, $urandom_range(0, 3) != 0, $urandom,
                                      31'($urandom)));
            end
            else if (p < 88)
                send_item(mk_other(fst_pkg::ACT_CLEAR, $urandom));
            else
                send_item(mk_other(fst_pkg::ACT_DROP, pick_key()));
        end
    endtask

    task automatic test_random_settings();
        logic [4:0] mp [5] = '{5'd4, 5'd1, 5'd24, 5'd31, 5'd8};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(fst_pkg::REG_MAX_PENDING, mp[ph]);
            write_reg(fst_pkg::REG_ENABLED, 5'(ph != 3 || $urandom_range(0, 1) != 0));
            run_random(140);
            wait_drained();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        fst_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = answers_due.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    // watchdog on cycles with no item, result or register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb_fetch_slot_table: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        table_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_disabled();
        test_random_settings();
        wait_drained();
        if (mismatches == 0 && answers_due.size() == 0)
            $display("tb_fetch_slot_table: done, clean");
        else
            $display("tb_fetch_slot_table: done, errors");
        $finish;
    end
endmodule

/* files.f */
src/fst_pkg.sv
src/fst_front.sv
src/fst_back.sv
src/fetch_slot_table.sv
src/fst_checker.sv
verif/tb_fetch_slot_table.sv
